FILE: src/itd_pkg.sv
package itd_pkg;

    // Field widths
    localparam int ValueW  = 32;
    localparam int CharW   = 6;
    localparam int NumDig  = 10;
    localparam int DigW    = 4;
    localparam int IdxW    = 4;
    localparam int StepW   = 5;

    // Character codes
    localparam logic [CharW-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CharW-1:0] ASCII_MINUS = 6'd45;

    // Last shift-and-adjust step of the conversion
    localparam logic [StepW-1:0] LAST_STEP = 5'(ValueW - 1);

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture sign and magnitude of a new request
        logic step;      // one shift-and-add-3 step
        logic prep;      // point at the leading nonzero digit
        logic dec;       // advance to the next lower digit
        logic sel_sign;  // drive the minus sign instead of a digit
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic neg;       // value is negative
        logic idx_zero;  // current digit is the units digit
    } t_stat;

endpackage

FILE: src/itd_dp.sv
module itd_dp
    import itd_pkg::*;
(
    input  logic              i_clk,
    input  logic [ValueW-1:0] i_value,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic [CharW-1:0]  o_char
);

    logic                             r_neg;
    logic [ValueW-1:0]                r_bin;
    logic [NumDig-1:0][DigW-1:0]      r_bcd;
    logic [IdxW-1:0]                  r_idx;

    logic [NumDig-1:0][DigW-1:0]      adj;
    logic [IdxW-1:0]                  lead;
    logic [DigW-1:0]                  digit;

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NumDig; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    // Find the leading nonzero digit; units digit when all are zero
    always_comb begin
        lead = '0;
        for (int i = 1; i < NumDig; i++) begin
            if (r_bcd[i] != '0) begin
                lead = IdxW'(i);
            end
        end
    end

    // Conversion and digit pointer registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[ValueW-1];
            r_bin <= i_value[ValueW-1] ? (ValueW'(0) - i_value) : i_value;
            r_bcd <= '0;
        end else if (i_cmd.step) begin
            // Shift the next magnitude bit into the units digit; the bit that
            // leaves the top digit is always zero for a 32-bit magnitude
            r_bcd <= (NumDig*DigW)'({adj, r_bin[ValueW-1]});
            r_bin <= {r_bin[ValueW-2:0], 1'b0};
        end
        if (i_cmd.prep) begin
            r_idx <= lead;
        end else if (i_cmd.dec) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    assign digit = r_bcd[r_idx];

    // Select minus sign or digit character
    assign o_char = i_cmd.sel_sign ? ASCII_MINUS : (ASCII_ZERO | {2'b00, digit});

    assign o_stat.neg      = r_neg;
    assign o_stat.idx_zero = (r_idx == '0);

endmodule

FILE: src/itd_ctrl.sv
module itd_ctrl
    import itd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output logic  o_out_last,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_DIGIT = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [StepW-1:0] r_cnt, n_cnt;
    logic             out_fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_SIGN) || (r_state == S_DIGIT);
    assign o_out_last  = (r_state == S_DIGIT) && i_stat.idx_zero;
    assign out_fire    = o_out_valid && i_out_ready;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_stat.neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                o_cmd.sel_sign = 1'b1;
                if (out_fire) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (out_fire) begin
                    if (i_stat.idx_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.dec = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: src/integer_to_decimal_text.sv
// Converts one signed 32-bit integer per request into its decimal ASCII text, most
// significant character first: a '-' for negative values (the most negative value
// included), no leading zeros, a single '0' for zero, and tlast on the final digit.
// One request is handled at a time. It is accepted, run through the shift-and-add-3
// binary-to-BCD loop over every magnitude bit, and the leading digit is located; then
// the characters (1 to 11 of them) are sent one character per cycle while the output
// side takes them, and a stalled output holds the current character in place.
// The input is ready again the cycle after the last character is taken.
module integer_to_decimal_text
    import itd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [5:0] character, [7:6] zero
    output logic        o_m_tlast
);

    t_cmd             cmd;
    t_stat            stat;
    logic [CharW-1:0] chr;

    itd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_last  (o_m_tlast),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    itd_dp u_dp (
        .i_clk   (i_clk),
        .i_value (i_s_tdata),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_char  (chr)
    );

    assign o_m_tdata = {2'b00, chr};

`ifndef SYNTH
    // Input side and output side are never open together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while output valid");

    // The final character is always a digit
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[5:0] != ASCII_MINUS))
        else $error("minus sign flagged as last");

    // After the last character is taken the block is ready again
    a_ready_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("not ready after last character");

    // An accepted request starts the conversion, no output next cycle
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (!o_m_tvalid && !o_s_tready))
        else $error("output or ready right after accept");
`endif

endmodule
